// ===== rtl/i2p_pkg.sv =====
// Shared constants, types and the precedence function for the infix-to-postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

	// Depth of the operator stack, which is also the number of cells in the chain.
	localparam int STACK_DEPTH = 32;
	// Width of the fill count and of the open-parenthesis count.
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	// Symbol bytes with a meaning of their own.
	localparam logic [7:0] SYM_ADD = 8'h2B;
	localparam logic [7:0] SYM_SUB = 8'h2D;
	localparam logic [7:0] SYM_MUL = 8'h2A;
	localparam logic [7:0] SYM_DIV = 8'h2F;
	localparam logic [7:0] SYM_MOD = 8'h25;
	localparam logic [7:0] SYM_POW = 8'h5E;
	localparam logic [7:0] SYM_LP  = 8'h28;
	localparam logic [7:0] SYM_RP  = 8'h29;

	// Error codes carried on every result word.
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_STRAY_RP = 2'd2,
		ERR_OPEN_LP  = 2'd3
	} err_code_t;

	// Shift command broadcast to every cell of the stack chain.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PUSH = 2'd1,
		CELL_POP  = 2'd2
	} cell_op_t;

	// Control bundle from the sequencer to the chain.
	typedef struct packed {
		cell_op_t   op;
		logic [7:0] sym;
	} cell_ctl_t;

	// Operator precedence: 0 for anything that is not an operator.
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			SYM_ADD, SYM_SUB:          p = 2'd1;
			SYM_MUL, SYM_DIV, SYM_MOD: p = 2'd2;
			SYM_POW:                   p = 2'd3;
			default:                   p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/i2p_cell.sv =====
// One stack cell: holds a byte and shifts with its neighbors on push or pop.
`timescale 1ns / 1ps

module i2p_cell (
	input  logic              clk,
	input  i2p_pkg::cell_ctl_t ctl,
	input  logic [7:0]        from_above,
	input  logic [7:0]        from_below,
	output logic [7:0]        q
);
	import i2p_pkg::*;

	logic [7:0] entry_q;

	// A push moves every entry one place deeper, a pop one place up.
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_PUSH: entry_q <= from_above;
			CELL_POP:  entry_q <= from_below;
			default:   entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule

// ===== rtl/i2p_ctrl.sv =====
// Sequencer for the converter: decides pops and pushes, holds counts and the result register.
`timescale 1ns / 1ps

module i2p_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         symbol,
	input  logic               end_of_expr,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_symbol,
	output logic               has_symbol,
	output logic               last,
	output logic [1:0]         error,
	input  logic [7:0]         top_sym,
	output i2p_pkg::cell_ctl_t cell_ctl
);
	import i2p_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPPOP,
		ST_RPPOP,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t           state_q, state_d;
	logic [7:0]       sym_q;
	logic [1:0]       prec_q;
	logic             end_q;
	err_code_t        err_q, step_err;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pc_q;
	logic             pend_valid_q;
	logic [7:0]       pend_sym_q;
	logic             out_valid_q;
	logic [7:0]       out_symbol_q;
	logic             out_has_q;
	logic             out_last_q;
	err_code_t        out_err_q;

	logic       accept, out_free, can_emit;
	logic       cnt_zero, stack_full, pc_zero, top_lp;
	logic [1:0] top_prec, in_prec;
	logic       ovf, stray_rp, open_after;
	logic       pop_emit, pop_drop, do_push, done_fire, out_load;
	logic       in_is_operand;
	cell_op_t   cop;
	logic [7:0] psym;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign can_emit   = !pend_valid_q || out_free;
	assign cnt_zero   = (cnt_q == '0);
	assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
	assign pc_zero    = (pc_q == '0);
	assign top_lp     = (top_sym == SYM_LP);
	assign top_prec   = prec_of(top_sym);
	assign in_prec    = prec_of(symbol);
	assign in_is_operand = (in_prec == 2'd0) && (symbol != SYM_LP) && (symbol != SYM_RP);

	// The whole step's error is known at acceptance: an operator overflows only when
	// nothing pops first, and the paren count tells whether a ')' or the flush fails.
	always_comb begin
		ovf        = 1'b0;
		stray_rp   = 1'b0;
		open_after = !pc_zero;
		if (in_prec != 2'd0) begin
			ovf = stack_full && (top_lp || (top_prec < in_prec));
		end else if (symbol == SYM_LP) begin
			ovf        = stack_full;
			open_after = !pc_zero || !stack_full;
		end else if (symbol == SYM_RP) begin
			stray_rp   = pc_zero;
			open_after = (pc_q > CNT_W'(1));
		end
		priority if (err_q != ERR_NONE) step_err = err_q;
		else if (ovf)                   step_err = ERR_OVERFLOW;
		else if (stray_rp)              step_err = ERR_STRAY_RP;
		else if (end_of_expr && open_after) step_err = ERR_OPEN_LP;
		else                            step_err = ERR_NONE;
	end

	// Next-state and stack command decisions.
	always_comb begin
		state_d   = state_q;
		cop       = CELL_HOLD;
		psym      = sym_q;
		pop_emit  = 1'b0;
		pop_drop  = 1'b0;
		do_push   = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_prec != 2'd0) begin
						state_d = ST_OPPOP;
					end else if (symbol == SYM_RP) begin
						state_d = ST_RPPOP;
					end else begin
						if (symbol == SYM_LP && !stack_full) begin
							do_push = 1'b1;
							psym    = symbol;
						end
						state_d = end_of_expr ? ST_FLUSH : ST_DONE;
					end
				end
			end
			ST_OPPOP: begin
				if (cnt_zero || top_lp || (top_prec < prec_q)) begin
					do_push = !stack_full;
					state_d = end_q ? ST_FLUSH : ST_DONE;
				end else if (can_emit) begin
					pop_emit = 1'b1;
				end
			end
			ST_RPPOP: begin
				if (cnt_zero) begin
					state_d = end_q ? ST_FLUSH : ST_DONE;
				end else if (top_lp) begin
					pop_drop = 1'b1;
					state_d  = end_q ? ST_FLUSH : ST_DONE;
				end else if (can_emit) begin
					pop_emit = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (cnt_zero) begin
					state_d = ST_DONE;
				end else if (top_lp) begin
					pop_drop = 1'b1;
				end else if (can_emit) begin
					pop_emit = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free || (!pend_valid_q && !end_q)) begin
					done_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
		endcase
		if (do_push) begin
			cop = CELL_PUSH;
		end else if (pop_emit || pop_drop) begin
			cop = CELL_POP;
		end
	end

	// A result is held back one place so the final one of a step can carry last.
	assign out_load = (pop_emit && pend_valid_q) ||
	                  (done_fire && (pend_valid_q || end_q));

	// State, counts, pending word and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			err_q        <= ERR_NONE;
			cnt_q        <= '0;
			pc_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				err_q <= step_err;
			end else if (done_fire && end_q) begin
				err_q <= ERR_NONE;
			end
			if (done_fire && end_q) begin
				cnt_q <= '0;
				pc_q  <= '0;
			end else if (do_push) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (psym == SYM_LP) begin
					pc_q <= pc_q + CNT_W'(1);
				end
			end else if (pop_emit || pop_drop) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (pop_drop) begin
					pc_q <= pc_q - CNT_W'(1);
				end
			end
			if (accept && in_is_operand) begin
				pend_valid_q <= 1'b1;
			end else if (pop_emit) begin
				pend_valid_q <= 1'b1;
			end else if (done_fire) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= symbol;
			prec_q <= in_prec;
			end_q  <= end_of_expr;
		end
		if (accept && in_is_operand) begin
			pend_sym_q <= symbol;
		end else if (pop_emit) begin
			pend_sym_q <= top_sym;
		end
		if (out_load) begin
			out_symbol_q <= pend_valid_q ? pend_sym_q : 8'd0;
			out_has_q    <= pend_valid_q;
			out_last_q   <= done_fire && end_q;
			out_err_q    <= err_q;
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign out_symbol   = out_symbol_q;
	assign has_symbol   = out_has_q;
	assign last         = out_last_q;
	assign error        = out_err_q;
	assign cell_ctl.op  = cop;
	assign cell_ctl.sym = psym;

endmodule

// ===== rtl/infix_to_postfix_converter_top.sv =====
// Top level of the infix-to-postfix converter: sequencer plus the chain of stack cells.
//
// Usage: one infix symbol byte enters per word on the input channel (in_valid,
// in_stall, symbol, end_of_expr); postfix words leave on the output channel
// (out_valid, out_stall, out_symbol, has_symbol, last, error). A word moves at a
// rising edge where valid is high and stall is low.
// The operator stack is a chain of STACK_DEPTH cells with the top in cell 0; a
// push or pop shifts the whole chain by one place.
// One symbol is handled at a time. An operator first pops every stacked operator
// of equal or higher precedence down to the nearest '(' and then is pushed if the
// stack has room; a ')' pops operators up to its '(', which it drops. On the last
// symbol of an expression the flush pops every stacked entry. Each word is held one
// place so the final one can be marked last: it enters the output register at the
// next pop of its step or when the step ends, so an operand inside an expression
// passes the pending register and then the output register. A stalled receiver
// freezes the output register, and the sequencer waits before each further emission, so nothing is lost.
// Reset empties the stack count, clears the error flag and the output valid flag;
// cell contents are left as they are and are only read below the fill count.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       end_of_expr,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic       has_symbol,
	output logic       last,
	output logic [1:0] error
);
	import i2p_pkg::*;

	cell_ctl_t  cell_ctl;
	logic [7:0] cell_q [STACK_DEPTH];

	// Sequencer and result register.
	i2p_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.symbol      (symbol),
		.end_of_expr (end_of_expr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_symbol  (out_symbol),
		.has_symbol  (has_symbol),
		.last        (last),
		.error       (error),
		.top_sym     (cell_q[0]),
		.cell_ctl    (cell_ctl)
	);

	// Chain of stack cells; cell 0 is the top and takes new symbols on a push.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [7:0] above, below;
		if (i == 0) begin : g_first
			assign above = cell_ctl.sym;
		end else begin : g_mid
			assign above = cell_q[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = cell_q[i];
		end else begin : g_inner
			assign below = cell_q[i+1];
		end
		i2p_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.from_above (above),
			.from_below (below),
			.q          (cell_q[i])
		);
	end

endmodule

// ===== rtl/i2p_checker.sv =====
// Port-level checks for the infix-to-postfix converter, bound to its top level.
`timescale 1ns / 1ps

module i2p_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] symbol,
	input logic       end_of_expr,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_symbol,
	input logic       has_symbol,
	input logic       last,
	input logic [1:0] error
);
	import i2p_pkg::*;

	// A stalled result word stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(last))
		else $error("stalled output word changed");

	// A bare end marker is always the last word and carries a zero byte.
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_symbol |-> last && (out_symbol == 8'd0))
		else $error("bare end marker malformed");

	// Parentheses never appear in the postfix stream.
	a_no_paren: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_symbol |-> (out_symbol != SYM_LP) && (out_symbol != SYM_RP))
		else $error("parenthesis emitted");

	// An accepted symbol keeps the input stalled in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a symbol");

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the infix-to-postfix converter, with a built-in shunting-yard predictor.
`timescale 1ns / 1ps

module tb_top;
	import i2p_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;

	// One postfix word as the block should produce it.
	typedef struct packed {
		logic [7:0] sym;
		logic       has;
		logic       last;
		logic [1:0] err;
	} postfix_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] symbol = 8'h00;
	logic       end_of_expr = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_symbol;
	logic       has_symbol;
	logic       last;
	logic [1:0] error;

	// Shadow of the operator stack and the sticky error.
	logic [7:0]    op_stack [STACK_DEPTH];
	int            op_depth = 0;
	err_code_t     sticky_err = ERR_NONE;
	postfix_word_t step_words [$];
	postfix_word_t pending_postfix [$];
	postfix_word_t want;

	// Infix symbols of the expression about to be sent.
	logic [7:0] infix_q [$];

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatch_cnt = 0;
	int symbols_sent = 0;
	int exprs_sent = 0;
	int words_checked = 0;
	int err_tally [4] = '{0, 0, 0, 0};

	infix_to_postfix_converter_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.symbol      (symbol),
		.end_of_expr (end_of_expr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_symbol  (out_symbol),
		.has_symbol  (has_symbol),
		.last        (last),
		.error       (error)
	);

	always #2 clk = ~clk;

	// Precedence rank of an operator byte; zero for everything else.
	function automatic int rank_of(input logic [7:0] c);
		case (c)
			SYM_ADD, SYM_SUB: return 1;
			SYM_MUL, SYM_DIV, SYM_MOD: return 2;
			SYM_POW: return 3;
			default: return 0;
		endcase
	endfunction

	task automatic note_err(input err_code_t code);
		if (sticky_err == ERR_NONE)
			sticky_err = code;
	endtask

	task automatic push_op(input logic [7:0] s);
		if (op_depth >= STACK_DEPTH) begin
			note_err(ERR_OVERFLOW);
		end else begin
			op_stack[op_depth] = s;
			op_depth++;
		end
	endtask

	task automatic emit_word(input logic [7:0] s);
		postfix_word_t w;
		w.sym = s;
		w.has = 1'b1;
		w.last = 1'b0;
		w.err = ERR_NONE;
		step_words.push_back(w);
	endtask

	// Shunting-yard step: queues the postfix words that one infix symbol causes.
	task automatic shunt_symbol(input logic [7:0] s, input logic eoe);
		postfix_word_t w;
		int r;
		bit found;
		r = rank_of(s);
		if (r > 0) begin
			while (op_depth > 0 && op_stack[op_depth - 1] != SYM_LP &&
					rank_of(op_stack[op_depth - 1]) >= r) begin
				op_depth--;
				emit_word(op_stack[op_depth]);
			end
			push_op(s);
		end else if (s == SYM_LP) begin
			push_op(s);
		end else if (s == SYM_RP) begin
			found = 0;
			while (op_depth > 0 && !found) begin
				op_depth--;
				if (op_stack[op_depth] == SYM_LP)
					found = 1;
				else
					emit_word(op_stack[op_depth]);
			end
			if (!found)
				note_err(ERR_STRAY_RP);
		end else begin
			emit_word(s);
		end

		// The end symbol flushes the stack; a leftover '(' is dropped as an error.
		if (eoe) begin
			while (op_depth > 0) begin
				op_depth--;
				if (op_stack[op_depth] == SYM_LP)
					note_err(ERR_OPEN_LP);
				else
					emit_word(op_stack[op_depth]);
			end
			if (step_words.size() == 0) begin
				w = '0;
				step_words.push_back(w);
			end
			w = step_words.pop_back();
			w.last = 1'b1;
			step_words.push_back(w);
		end

		foreach (step_words[i]) begin
			w = step_words[i];
			w.err = sticky_err;
			pending_postfix.push_back(w);
		end
		step_words.delete();

		if (eoe) begin
			err_tally[sticky_err]++;
			op_depth = 0;
			sticky_err = ERR_NONE;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_cnt++;
	endtask

	// Offers one word, with a random gap first, and waits until it is taken.
	task automatic send_symbol(input logic [7:0] s, input logic eoe);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= s;
		end_of_expr <= eoe;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		shunt_symbol(s, eoe);
		symbols_sent++;
	endtask

	task automatic send_infix();
		foreach (infix_q[i])
			send_symbol(infix_q[i], i == infix_q.size() - 1);
		exprs_sent++;
	endtask

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 5))
			0: return SYM_ADD;
			1: return SYM_SUB;
			2: return SYM_MUL;
			3: return SYM_DIV;
			4: return SYM_MOD;
			default: return SYM_POW;
		endcase
	endfunction

	// Any byte that is neither an operator nor a parenthesis.
	function automatic logic [7:0] rand_operand();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (rank_of(b) != 0 || b == SYM_LP || b == SYM_RP);
		return b;
	endfunction

	// Builds a balanced expression; lp_pct sets how eagerly parentheses nest.
	task automatic build_balanced(input int n_operands, input int lp_pct);
		int open;
		infix_q.delete();
		open = 0;
		for (int i = 0; i < n_operands; i++) begin
			if (i > 0)
				infix_q.push_back(rand_operator());
			while ($urandom_range(0, 99) < lp_pct && open < 40) begin
				infix_q.push_back(SYM_LP);
				open++;
			end
			infix_q.push_back(rand_operand());
			while (open > 0 && $urandom_range(0, 2) == 0) begin
				infix_q.push_back(SYM_RP);
				open--;
			end
		end
		while (open > 0) begin
			infix_q.push_back(SYM_RP);
			open--;
		end
	endtask

	// Damages a balanced expression with a stray parenthesis or a lost symbol.
	task automatic break_expr();
		int idx;
		idx = $urandom_range(0, infix_q.size() - 1);
		case ($urandom_range(0, 2))
			0: infix_q.insert(idx, SYM_LP);
			1: infix_q.insert(idx, SYM_RP);
			default: if (infix_q.size() > 1) infix_q.delete(idx);
		endcase
	endtask

	task automatic build_noise(input int len);
		infix_q.delete();
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0: infix_q.push_back(rand_operator());
				1: infix_q.push_back($urandom_range(0, 1) ? SYM_LP : SYM_RP);
				default: infix_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// Directed expressions: every operator, edge bytes and the stray ')' and open '(' errors.
	task automatic test_directed();
		infix_q = '{"#", SYM_SUB, "b", SYM_MUL, "c", SYM_POW, "d", SYM_DIV, "e",
				SYM_MOD, "f", SYM_ADD, "g"};
		send_infix();
		infix_q = '{SYM_LP, 8'h00, SYM_ADD, "b", SYM_RP, SYM_MUL, 8'hFF};
		send_infix();
		// A lone ')' gives a bare end marker with the stray-paren error.
		infix_q = '{SYM_RP};
		send_infix();
		// A lone '(' is discarded at the flush.
		infix_q = '{SYM_LP};
		send_infix();
		infix_q = '{SYM_ADD};
		send_infix();
		// The first error sticks even when a second one follows.
		infix_q = '{"a", SYM_RP, SYM_LP};
		send_infix();
	endtask

	// Full stack depth, overflow on '(' and overflow on an operator.
	task automatic test_stack_limits();
		infix_q.delete();
		repeat (STACK_DEPTH + 1) infix_q.push_back(SYM_LP);
		send_infix();
		infix_q.delete();
		repeat (STACK_DEPTH) infix_q.push_back(SYM_LP);
		infix_q.push_back("a");
		repeat (STACK_DEPTH) infix_q.push_back(SYM_RP);
		send_infix();
		infix_q.delete();
		repeat (STACK_DEPTH) infix_q.push_back(SYM_LP);
		infix_q.push_back("a");
		infix_q.push_back(SYM_ADD);
		infix_q.push_back("b");
		repeat (STACK_DEPTH) infix_q.push_back(SYM_RP);
		send_infix();
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		in_idle_pct = 0;
		out_stall_pct <= 0;
		hold_reqs <= hold_reqs + 1;
		build_balanced(24, 30);
		send_infix();
		build_balanced(12, 20);
		send_infix();
	endtask

	// Random mix, mostly balanced expressions, under one idling pattern.
	task automatic test_random(input int in_pct, input int out_pct, input int n_items);
		int start;
		int k;
		in_idle_pct = in_pct;
		out_stall_pct <= out_pct;
		start = symbols_sent;
		while (symbols_sent - start < n_items) begin
			k = $urandom_range(0, 99);
			if (k < 8) begin
				build_balanced($urandom_range(4, 12), 85);
			end else if (k < 75) begin
				build_balanced($urandom_range(1, 8), 25);
			end else if (k < 90) begin
				build_balanced($urandom_range(1, 6), 30);
				break_expr();
			end else begin
				build_noise($urandom_range(1, 8));
			end
			send_infix();
		end
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		out_stall_pct <= 0;
		while (pending_postfix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d symbols in %0d expressions; checked %0d postfix words.",
				symbols_sent, exprs_sent, words_checked);
		$display("Expressions ending with overflow %0d, stray ')' %0d, open '(' %0d.",
				err_tally[ERR_OVERFLOW], err_tally[ERR_STRAY_RP], err_tally[ERR_OPEN_LP]);
		if (mismatch_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	endtask

	// Main sequence.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_limits();
		test_random(0, 0, 40);
		test_random(51, 0, 40);
		test_backpressure();
		test_random(0, 51, 40);
		test_random(9, 9, 40);
		finish_run();
	end

	// Output side: check each accepted word, then pick the next stall value.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			words_checked++;
			if (pending_postfix.size() == 0) begin
				report_mismatch($sformatf("unexpected word sym=%h has=%b last=%b err=%0d",
						out_symbol, has_symbol, last, error));
			end else begin
				want = pending_postfix.pop_front();
				if (out_symbol !== want.sym)
					report_mismatch($sformatf("out_symbol %h, want %h", out_symbol, want.sym));
				if (has_symbol !== want.has)
					report_mismatch($sformatf("has_symbol %b, want %b", has_symbol, want.has));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
				if (error !== want.err)
					report_mismatch($sformatf("error %0d, want %0d", error, want.err));
			end
		end
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < out_stall_pct);
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d words still due.",
					quiet_cycles, pending_postfix.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/i2p_pkg.sv
rtl/i2p_cell.sv
rtl/i2p_ctrl.sv
rtl/infix_to_postfix_converter_top.sv
rtl/i2p_checker.sv
test/tb_top.sv
